>>> rtl/weekly_alarm_table_macros.svh
// Assertion macros shared by the alarm table RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef WEEKLY_ALARM_TABLE_MACROS_SVH
`define WEEKLY_ALARM_TABLE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define WAT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define WAT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wat_pkg.sv
package wat_pkg;

  // Table depth default and the cap on fired alarms per check.
  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned MaxResults    = 16;

  // Date code scales and time limits.
  localparam logic [25:0] YearScale  = 26'd10000;
  localparam logic [25:0] MonthScale = 26'd100;
  localparam logic [4:0]  HourMax    = 5'd23;
  localparam logic [5:0]  MinuteMax  = 6'd59;

  // Field widths.
  localparam int unsigned IdW    = 16;
  localparam int unsigned DateW  = 25;

  typedef enum logic [2:0] {
    KIND_CHECK  = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_UPDATE = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_ENABLE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_HOUR   = 3'd2,
    ST_BAD_MINUTE = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_SH,
    S_SW,
    S_ADD,
    S_DONE
  } state_e;

  // One table entry: settings and the date code of the last run.
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic             en;
    logic [6:0]       mask;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [7:0]       target;
    logic [3:0]       cmd;
    logic [DateW-1:0] last_run;
  } entry_t;

endpackage

>>> rtl/wat_if.sv
// Request channel: one word per command or minute check.
interface wat_req_if import wat_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [15:0] entry_id;
  logic [7:0]  target_id;
  logic [3:0]  command_code;
  logic [6:0]  day_mask;
  logic        enable_flag;

  modport source (
    output valid, kind, weekday, hour, minute, year, month, day_of_month,
           entry_id, target_id, command_code, day_mask, enable_flag,
    input  ready
  );
  modport sink (
    input  valid, kind, weekday, hour, minute, year, month, day_of_month,
           entry_id, target_id, command_code, day_mask, enable_flag,
    output ready
  );
endinterface

// Response channel: one word per result.
interface wat_rsp_if import wat_pkg::*; ();
  logic       valid;
  logic       ready;
  status_e    status;
  logic       fired;
  logic [15:0] result_id;
  logic [7:0] fired_target;
  logic [3:0] fired_command;
  logic       last;

  modport source (
    output valid, status, fired, result_id, fired_target, fired_command, last,
    input  ready
  );
  modport sink (
    input  valid, status, fired, result_id, fired_target, fired_command, last,
    output ready
  );
endinterface

>>> rtl/weekly_alarm_table.sv
// Weekly alarm table.
// Commands and minute checks arrive as words on req_i; results leave on rsp_o,
// both valid/ready, a word moving when valid and ready are high at a clock edge.
// A minute check gives one word per fired alarm, in table order, or one word
// with fired low when nothing fires; the last word of each request has last set.
// Edits (add, update, delete, set enable) give exactly one word.
// The table lives in one memory with a registered read port, walked by a
// sequencer: each entry visited is read, then evaluated and written back.
// A delete also moves every later entry up one place.
// req_i.ready is high only while the sequencer is idle; one request is in work
// at a time. The result register decouples the sides: a new request is taken
// while the final word still waits, and a stalled receiver holds the walk only
// when a further fired word has nowhere to go.
// Reset empties the table (count zero, next id one) at once; entries need no
// clearing since only entries below the count are ever read.
`include "weekly_alarm_table_macros.svh"

module weekly_alarm_table import wat_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wat_req_if.sink   req_i,
  wat_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned FIRE_W = $clog2(MaxResults + 1);

  // Table memory and its registered read data.
  entry_t             mem_q [MAX_ENTRIES];
  entry_t             rdata_q;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  entry_t             mem_wdata;

  state_e             state_q, state_d;
  logic [2:0]         kind_q, kind_d;
  logic [2:0]         wd_q, wd_d;
  logic [4:0]         hour_q, hour_d;
  logic [5:0]         min_q, min_d;
  logic [DateW-1:0]   today_q, today_d;
  logic [IdW-1:0]     eid_q, eid_d;
  logic [7:0]         tgt_q, tgt_d;
  logic [3:0]         cmd_q, cmd_d;
  logic [6:0]         mask_q, mask_d;
  logic               en_q, en_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IdW-1:0]     next_id_q, next_id_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [FIRE_W-1:0]  nfire_q, nfire_d;
  logic               pend_valid_q, pend_valid_d;
  logic [IdW-1:0]     pend_id_q, pend_id_d;
  logic [7:0]         pend_tgt_q, pend_tgt_d;
  logic [3:0]         pend_cmd_q, pend_cmd_d;
  status_e            status_q, status_d;
  logic [IdW-1:0]     rid_q, rid_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic               out_fired_q, out_fired_d;
  logic [IdW-1:0]     out_rid_q, out_rid_d;
  logic [7:0]         out_tgt_q, out_tgt_d;
  logic [3:0]         out_cmd_q, out_cmd_d;
  logic               out_last_q, out_last_d;

  logic               req_acc, out_free, is_check;
  logic               check_hit, id_hit, scan_end, shift_end, ev_stall;
  logic [7:0]         mask8;
  logic [CNT_W:0]     idx_nxt;
  logic [DateW-1:0]   today_w;

  // Handshake and scan conditions.
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign is_check    = (kind_q == KIND_CHECK);
  assign idx_nxt     = (CNT_W+1)'(idx_q) + 1'b1;

  // A weekday of seven lands on the padding bit and matches nothing.
  assign mask8     = {1'b0, rdata_q.mask};
  assign check_hit = rdata_q.en && mask8[wd_q] && (rdata_q.hour == hour_q) &&
                     (rdata_q.minute == min_q) && (rdata_q.last_run != today_q);
  assign id_hit    = (rdata_q.id == eid_q);
  assign scan_end  = (idx_q >= count_q) ||
                     (is_check && (nfire_q == FIRE_W'(MaxResults)));
  assign shift_end = (idx_nxt >= (CNT_W+1)'(count_q));
  assign ev_stall  = is_check && check_hit && pend_valid_q && !out_free;

  // Date code of the incoming request.
  assign today_w = DateW'(26'(req_i.year) * YearScale + 26'(req_i.month) * MonthScale +
                          26'(req_i.day_of_month));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          case (kind_e'(req_i.kind))
            KIND_CHECK, KIND_UPDATE, KIND_DELETE, KIND_ENABLE: state_d = S_RD;
            KIND_ADD: state_d = S_ADD;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_RD:   state_d = scan_end ? S_DONE : S_EV;
      S_EV: begin
        if (is_check) begin
          state_d = ev_stall ? S_EV : S_RD;
        end else if (id_hit) begin
          state_d = (kind_q == KIND_DELETE) ? S_SH : S_DONE;
        end else begin
          state_d = S_RD;
        end
      end
      S_SH:   state_d = shift_end ? S_DONE : S_SW;
      S_SW:   state_d = S_SH;
      S_ADD:  state_d = S_DONE;
      S_DONE: state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory ports and result register loading.
  always_comb begin
    kind_d       = kind_q;
    wd_d         = wd_q;
    hour_d       = hour_q;
    min_d        = min_q;
    today_d      = today_q;
    eid_d        = eid_q;
    tgt_d        = tgt_q;
    cmd_d        = cmd_q;
    mask_d       = mask_q;
    en_d         = en_q;
    count_d      = count_q;
    next_id_d    = next_id_q;
    idx_d        = idx_q;
    nfire_d      = nfire_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    pend_tgt_d   = pend_tgt_q;
    pend_cmd_d   = pend_cmd_q;
    status_d     = status_q;
    rid_d        = rid_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = idx_q[IDX_W-1:0];
    mem_raddr    = idx_q[IDX_W-1:0];
    mem_wdata    = rdata_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_fired_d  = out_fired_q;
    out_rid_d    = out_rid_q;
    out_tgt_d    = out_tgt_q;
    out_cmd_d    = out_cmd_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          kind_d       = req_i.kind;
          wd_d         = req_i.weekday;
          hour_d       = req_i.hour;
          min_d        = req_i.minute;
          today_d      = today_w;
          eid_d        = req_i.entry_id;
          tgt_d        = req_i.target_id;
          cmd_d        = req_i.command_code;
          mask_d       = req_i.day_mask;
          en_d         = req_i.enable_flag;
          idx_d        = '0;
          nfire_d      = '0;
          pend_valid_d = 1'b0;
          status_d     = ST_OK;
          rid_d        = '0;
        end
      end
      S_RD: begin
        if (!scan_end) begin
          mem_re = 1'b1;
        end else if (!is_check) begin
          status_d = ST_NOT_FOUND;
        end
      end
      S_EV: begin
        if (is_check) begin
          if (check_hit && !ev_stall) begin
            // Record today's run, push the previous fire and hold this one.
            mem_we             = 1'b1;
            mem_wdata.last_run = today_q;
            if (pend_valid_q) begin
              out_valid_d  = 1'b1;
              out_status_d = ST_OK;
              out_fired_d  = 1'b1;
              out_rid_d    = pend_id_q;
              out_tgt_d    = pend_tgt_q;
              out_cmd_d    = pend_cmd_q;
              out_last_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = rdata_q.id;
            pend_tgt_d   = rdata_q.target;
            pend_cmd_d   = rdata_q.cmd;
            nfire_d      = nfire_q + 1'b1;
            idx_d        = idx_nxt[CNT_W-1:0];
          end else if (!check_hit) begin
            idx_d = idx_nxt[CNT_W-1:0];
          end
        end else if (id_hit) begin
          // Update keeps the id and last run; set enable touches the flag only.
          if (kind_q == KIND_UPDATE) begin
            mem_we           = 1'b1;
            mem_wdata.en     = en_q;
            mem_wdata.mask   = mask_q;
            mem_wdata.hour   = hour_q;
            mem_wdata.minute = min_q;
            mem_wdata.target = tgt_q;
            mem_wdata.cmd    = cmd_q;
          end else if (kind_q == KIND_ENABLE) begin
            mem_we       = 1'b1;
            mem_wdata.en = en_q;
          end
        end else begin
          idx_d = idx_nxt[CNT_W-1:0];
        end
      end
      S_SH: begin
        // Move the following entry up one place, or close the table.
        if (shift_end) begin
          count_d = count_q - 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_nxt[IDX_W-1:0];
        end
      end
      S_SW: begin
        mem_we = 1'b1;
        idx_d  = idx_nxt[CNT_W-1:0];
      end
      S_ADD: begin
        if (count_q >= CNT_W'(MAX_ENTRIES)) begin
          status_d = ST_FULL;
        end else begin
          // The id is taken even when the time is rejected.
          rid_d     = next_id_q;
          next_id_d = next_id_q + 1'b1;
          if (hour_q > HourMax) begin
            status_d = ST_BAD_HOUR;
          end else if (min_q > MinuteMax) begin
            status_d = ST_BAD_MINUTE;
          end else begin
            mem_we             = 1'b1;
            mem_waddr          = count_q[IDX_W-1:0];
            mem_wdata.id       = next_id_q;
            mem_wdata.en       = en_q;
            mem_wdata.mask     = mask_q;
            mem_wdata.hour     = hour_q;
            mem_wdata.minute   = min_q;
            mem_wdata.target   = tgt_q;
            mem_wdata.cmd      = cmd_q;
            mem_wdata.last_run = '0;
            count_d            = count_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        // Final word: the held fire, or the status of the request.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_fired_d  = pend_valid_q;
          out_rid_d    = pend_valid_q ? pend_id_q : rid_q;
          out_tgt_d    = pend_valid_q ? pend_tgt_q : 8'd0;
          out_cmd_d    = pend_valid_q ? pend_cmd_q : 4'd0;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: begin
        pend_valid_d = 1'b0;
      end
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      next_id_q    <= IdW'(1);
      idx_q        <= '0;
      nfire_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      next_id_q    <= next_id_d;
      idx_q        <= idx_d;
      nfire_q      <= nfire_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    wd_q         <= wd_d;
    hour_q       <= hour_d;
    min_q        <= min_d;
    today_q      <= today_d;
    eid_q        <= eid_d;
    tgt_q        <= tgt_d;
    cmd_q        <= cmd_d;
    mask_q       <= mask_d;
    en_q         <= en_d;
    pend_id_q    <= pend_id_d;
    pend_tgt_q   <= pend_tgt_d;
    pend_cmd_q   <= pend_cmd_d;
    status_q     <= status_d;
    rid_q        <= rid_d;
    out_status_q <= out_status_d;
    out_fired_q  <= out_fired_d;
    out_rid_q    <= out_rid_d;
    out_tgt_q    <= out_tgt_d;
    out_cmd_q    <= out_cmd_d;
    out_last_q   <= out_last_d;
  end

  // Result channel.
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.fired         = out_fired_q;
  assign rsp_o.result_id     = out_rid_q;
  assign rsp_o.fired_target  = out_tgt_q;
  assign rsp_o.fired_command = out_cmd_q;
  assign rsp_o.last          = out_last_q;

  // Checks on the sequencer.
  `WAT_ASSERT_ALWAYS(a_count_in_range, count_q <= CNT_W'(MAX_ENTRIES), "count above depth")
  `WAT_ASSERT_IMPL(a_no_write_idle, mem_we, state_q != S_IDLE && state_q != S_DONE, "write while idle")
  `WAT_ASSERT_IMPL(a_pend_only_check, pend_valid_q, kind_q == KIND_CHECK, "held fire outside check")
  `WAT_ASSERT_IMPL(a_pend_counted, pend_valid_q, nfire_q != '0, "held fire not counted")
  `WAT_ASSERT_IMPL(a_shift_in_table, state_q == S_SW, idx_nxt < (CNT_W+1)'(count_q), "shift past end")

endmodule

>>> test/wat_result_checker.sv
// Passive checker for the weekly alarm table.
// It watches both channels, keeps its own copy of the alarm table, and checks
// every result word against the oldest word still due.
module wat_result_checker
  import wat_pkg::*;
#(
  parameter int unsigned DEPTH = MaxEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wat_req_if          req_i,
  wat_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned words_o,
  output int unsigned fires_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e     status;
    logic        fired;
    logic [15:0] alarm_id;
    logic [7:0]  target;
    logic [3:0]  command;
    logic        last;
  } result_word_t;

  // Result words still due from the block, oldest first.
  result_word_t due_results[$];

  // Shadow of the alarm table in table order.
  entry_t         alarm_tab [DEPTH];
  int unsigned    alarm_cnt = 0;
  logic [IdW-1:0] next_alarm_id = 1;

  int unsigned mismatches = 0;
  int unsigned words_seen = 0;
  int unsigned fires_seen = 0;

  // Prints one line per mismatch and counts it.
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic push_result(input status_e st, input logic fired,
                             input logic [15:0] id, input logic [7:0] tgt,
                             input logic [3:0] cmd, input logic last);
    result_word_t r;
    r = '{status: st, fired: fired, alarm_id: id, target: tgt, command: cmd,
          last: last};
    due_results = {due_results, r};
  endtask

  // First entry in table order that carries the id, or -1.
  function automatic int find_alarm(input logic [15:0] id);
    for (int i = 0; i < int'(alarm_cnt); i++) begin
      if (alarm_tab[i].id == id) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Works out the result words of one accepted request word and updates the table.
  task automatic apply_request();
    logic [31:0]    code;
    logic [24:0]    today;
    logic [7:0]     day_sel;
    logic [6:0]     day_bit;
    int unsigned    fired_n;
    int             idx;
    logic [IdW-1:0] take_id;
    case (req_i.kind)
      KIND_CHECK: begin
        code = 32'(req_i.year) * 32'(YearScale) + 32'(req_i.month) * 32'(MonthScale)
             + 32'(req_i.day_of_month);
        today = code[24:0];
        // Weekday seven shifts past the mask and matches nothing.
        day_sel = 8'd1 << req_i.weekday;
        day_bit = day_sel[6:0];
        fired_n = 0;
        for (int i = 0; i < int'(alarm_cnt); i++) begin
          if (fired_n >= MaxResults) begin
            break;
          end
          if (alarm_tab[i].en && (alarm_tab[i].mask & day_bit) != '0 &&
              alarm_tab[i].hour == req_i.hour && alarm_tab[i].minute == req_i.minute &&
              alarm_tab[i].last_run != today) begin
            alarm_tab[i].last_run = today;
            push_result(ST_OK, 1'b1, alarm_tab[i].id, alarm_tab[i].target,
                        alarm_tab[i].cmd, 1'b0);
            fired_n++;
          end
        end
        if (fired_n == 0) begin
          push_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          due_results[due_results.size() - 1].last = 1'b1;
        end
      end
      KIND_ADD: begin
        if (alarm_cnt >= DEPTH) begin
          push_result(ST_FULL, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          // The id is spent even when the time turns out to be bad.
          take_id = next_alarm_id;
          next_alarm_id++;
          if (req_i.hour > HourMax) begin
            push_result(ST_BAD_HOUR, 1'b0, take_id, '0, '0, 1'b1);
          end else if (req_i.minute > MinuteMax) begin
            push_result(ST_BAD_MINUTE, 1'b0, take_id, '0, '0, 1'b1);
          end else begin
            alarm_tab[alarm_cnt] = '{id: take_id, en: req_i.enable_flag,
                                     mask: req_i.day_mask, hour: req_i.hour,
                                     minute: req_i.minute, target: req_i.target_id,
                                     cmd: req_i.command_code, last_run: '0};
            alarm_cnt++;
            push_result(ST_OK, 1'b0, take_id, '0, '0, 1'b1);
          end
        end
      end
      KIND_UPDATE, KIND_DELETE, KIND_ENABLE: begin
        idx = find_alarm(req_i.entry_id);
        if (idx < 0) begin
          push_result(ST_NOT_FOUND, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          case (req_i.kind)
            KIND_UPDATE: begin
              // Id and last run stay; no range check on the time.
              alarm_tab[idx].hour   = req_i.hour;
              alarm_tab[idx].minute = req_i.minute;
              alarm_tab[idx].target = req_i.target_id;
              alarm_tab[idx].cmd    = req_i.command_code;
              alarm_tab[idx].mask   = req_i.day_mask;
              alarm_tab[idx].en     = req_i.enable_flag;
            end
            KIND_DELETE: begin
              for (int i = idx; i + 1 < int'(alarm_cnt); i++) begin
                alarm_tab[i] = alarm_tab[i + 1];
              end
              alarm_cnt--;
            end
            default: begin
              alarm_tab[idx].en = req_i.enable_flag;
            end
          endcase
          push_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
        end
      end
      default: begin
        push_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
      end
    endcase
  endtask

  // Compares one accepted result word with the oldest one due.
  task automatic check_result();
    result_word_t want;
    words_seen++;
    if (rsp_i.fired === 1'b1) begin
      fires_seen++;
    end
    if (due_results.size() == 0) begin
      note_mismatch("result word with none due", 32'(rsp_i.result_id), '0);
    end else begin
      want = due_results.pop_front();
      if (rsp_i.status !== want.status) begin
        note_mismatch("status", 32'(rsp_i.status), 32'(want.status));
      end
      if (rsp_i.fired !== want.fired) begin
        note_mismatch("fired", 32'(rsp_i.fired), 32'(want.fired));
      end
      if (rsp_i.result_id !== want.alarm_id) begin
        note_mismatch("result_id", 32'(rsp_i.result_id), 32'(want.alarm_id));
      end
      if (rsp_i.fired_target !== want.target) begin
        note_mismatch("fired_target", 32'(rsp_i.fired_target), 32'(want.target));
      end
      if (rsp_i.fired_command !== want.command) begin
        note_mismatch("fired_command", 32'(rsp_i.fired_command), 32'(want.command));
      end
      if (rsp_i.last !== want.last) begin
        note_mismatch("last", 32'(rsp_i.last), 32'(want.last));
      end
    end
  endtask

  // Both channels are sampled at the clock edge; the counts go out as registered outputs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_cnt = 0;
      next_alarm_id = 1;
      due_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      words_o      <= 0;
      fires_o      <= 0;
    end else begin
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        check_result();
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        apply_request();
      end
      fail_count_o <= mismatches;
      pending_o    <= due_results.size();
      words_o      <= words_seen;
      fires_o      <= fires_seen;
    end
  end

endmodule

>>> test/tb.sv
// Stimulus and verdict for the weekly alarm table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wat_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [15:0] entry_id;
    logic [7:0]  target;
    logic [3:0]  command;
    logic [6:0]  mask;
    logic        en;
  } req_word_t;

  localparam int unsigned ReqBits        = $bits(req_word_t);
  localparam logic [2:0]  NoWeekday      = 3'd7;
  localparam logic [2:0]  FirstSpareKind = 3'd5;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned TailCycles     = 48;

  logic clk_i = 1'b0;
  logic rst_ni;

  wat_req_if req_bus ();
  wat_rsp_if rsp_bus ();

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned words_checked;
  int unsigned fires_seen;

  // Phase flags shared with the receiver process.
  bit          calm = 1'b0;
  int unsigned hold_asks = 0;

  // Ids believed to live in the table, in table order, and the id an add takes next.
  logic [15:0] live_ids[$];
  logic [15:0] next_free_id;

  // A few alarm times reused by adds and checks so that alarms actually fire.
  logic [4:0]  pool_hr [4];
  logic [5:0]  pool_mn [4];
  logic [11:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  weekly_alarm_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  wat_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_bus),
    .rsp_i        (rsp_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .words_o      (words_checked),
    .fires_o      (fires_seen)
  );

  // Every field random at full width; the builders below override what matters.
  function automatic req_word_t noise_word();
    req_word_t w;
    w = ReqBits'({$urandom, $urandom, $urandom});
    return w;
  endfunction

  function automatic req_word_t minute_tick(input logic [2:0] wd, input logic [4:0] hr,
                                            input logic [5:0] mn, input logic [11:0] yr,
                                            input logic [3:0] mo, input logic [4:0] dm);
    req_word_t w;
    w = noise_word();
    w.kind    = KIND_CHECK;
    w.weekday = wd;
    w.hour    = hr;
    w.minute  = mn;
    w.year    = yr;
    w.month   = mo;
    w.dom     = dm;
    return w;
  endfunction

  function automatic req_word_t alarm_edit(input kind_e kind, input logic [15:0] eid,
                                           input logic [4:0] hr, input logic [5:0] mn,
                                           input logic [6:0] mask, input logic en,
                                           input logic [7:0] tgt, input logic [3:0] cmd);
    req_word_t w;
    w = noise_word();
    w.kind     = kind;
    w.entry_id = eid;
    w.hour     = hr;
    w.minute   = mn;
    w.mask     = mask;
    w.en       = en;
    w.target   = tgt;
    w.command  = cmd;
    return w;
  endfunction

  function automatic req_word_t alarm_add(input logic [4:0] hr, input logic [5:0] mn,
                                          input logic [6:0] mask, input logic en,
                                          input logic [7:0] tgt, input logic [3:0] cmd);
    return alarm_edit(KIND_ADD, 16'($urandom), hr, mn, mask, en, tgt, cmd);
  endfunction

  // Mostly a live id, sometimes a near miss or any id at all.
  function automatic logic [15:0] pick_id();
    if (live_ids.size() != 0 && $urandom_range(99) < 80) begin
      return live_ids[$urandom_range(live_ids.size() - 1)];
    end
    if ($urandom_range(3) == 0) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(next_free_id));
  endfunction

  // Offers one request word, at times after a random gap, and waits until it is taken.
  task automatic send_word(input req_word_t w);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 14) begin
      gap = $urandom_range(3, 1);
    end
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.kind         <= w.kind;
    req_bus.weekday      <= w.weekday;
    req_bus.hour         <= w.hour;
    req_bus.minute       <= w.minute;
    req_bus.year         <= w.year;
    req_bus.month        <= w.month;
    req_bus.day_of_month <= w.dom;
    req_bus.entry_id     <= w.entry_id;
    req_bus.target_id    <= w.target;
    req_bus.command_code <= w.command;
    req_bus.day_mask     <= w.mask;
    req_bus.enable_flag  <= w.en;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    // Keep the id list in step so that edits can aim at live alarms.
    if (w.kind == KIND_ADD && live_ids.size() < MaxEntriesDef) begin
      if (w.hour <= HourMax && w.minute <= MinuteMax) begin
        live_ids = {live_ids, next_free_id};
      end
      next_free_id++;
    end else if (w.kind == KIND_DELETE) begin
      for (int i = 0; i < live_ids.size(); i++) begin
        if (live_ids[i] == w.entry_id) begin
          live_ids.delete(i);
          break;
        end
      end
    end
  endtask

  // Stops offering words until every due result word has come back.
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Adds with a bad hour or minute: each spends an id and stores nothing.
  task automatic skip_ids(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(1) == 0) begin
        send_word(alarm_add(5'($urandom_range(31, 24)), 6'($urandom), 7'($urandom),
                            1'($urandom), 8'($urandom), 4'($urandom)));
      end else begin
        send_word(alarm_add(5'($urandom_range(23)), 6'($urandom_range(63, 60)),
                            7'($urandom), 1'($urandom), 8'($urandom), 4'($urandom)));
      end
    end
  endtask

  // Random traffic: mostly well-formed checks and edits on live ids, some noise.
  task automatic run_random(input int unsigned n);
    req_word_t   w;
    int unsigned pick;
    int unsigned t;
    for (int unsigned k = 0; k < n; k++) begin
      if (k == n / 3) calm = 1'b1;
      if (k == n / 3 + 60) calm = 1'b0;
      if (k == n / 2) hold_asks++;
      pick = $urandom_range(99);
      t = $urandom_range(3);
      if (pick < 38) begin
        if ($urandom_range(99) < 35) begin
          if ($urandom_range(7) == 0) begin
            cur_year  = 12'($urandom);
            cur_month = 4'($urandom);
            cur_day   = 5'($urandom);
          end else begin
            cur_year  = 12'($urandom_range(2099, 1970));
            cur_month = 4'($urandom_range(12, 1));
            cur_day   = 5'($urandom_range(31, 1));
          end
        end
        w = minute_tick(($urandom_range(9) == 0) ? NoWeekday : 3'($urandom_range(6)),
                        pool_hr[t], pool_mn[t], cur_year, cur_month, cur_day);
      end else if (pick < 60) begin
        w = alarm_add(pool_hr[t], pool_mn[t], 7'($urandom), $urandom_range(99) < 80,
                      8'($urandom), 4'($urandom));
      end else if (pick < 72) begin
        w = alarm_edit(KIND_UPDATE, pick_id(), pool_hr[t], pool_mn[t], 7'($urandom),
                       $urandom_range(99) < 80, 8'($urandom), 4'($urandom));
      end else if (pick < 82) begin
        w = noise_word();
        w.kind = KIND_DELETE;
        w.entry_id = pick_id();
      end else if (pick < 94) begin
        w = noise_word();
        w.kind = KIND_ENABLE;
        w.entry_id = pick_id();
      end else begin
        w = noise_word();
      end
      // Now and then the time is anything the field can hold.
      if (pick < 72 && $urandom_range(99) < 15) begin
        w.hour   = 5'($urandom);
        w.minute = 6'($urandom);
      end
      send_word(w);
      if (k % 60 == 59) begin
        drain_results();
      end
    end
  endtask

  // Receiver: random stalls, a calm stretch, and a long hold-off on request.
  initial begin : rsp_side
    int unsigned seen_asks;
    seen_asks = 0;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_asks != seen_asks) begin
        seen_asks = hold_asks;
        rsp_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      rsp_bus.ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  initial begin : stimulus
    req_word_t   w;
    req_bus.valid        <= 1'b0;
    req_bus.kind         <= KIND_CHECK;
    req_bus.weekday      <= '0;
    req_bus.hour         <= '0;
    req_bus.minute       <= '0;
    req_bus.year         <= '0;
    req_bus.month        <= '0;
    req_bus.day_of_month <= '0;
    req_bus.entry_id     <= '0;
    req_bus.target_id    <= '0;
    req_bus.command_code <= '0;
    req_bus.day_mask     <= '0;
    req_bus.enable_flag  <= 1'b0;
    rst_ni <= 1'b0;
    next_free_id = 16'd1;
    pool_hr[0] = '0;
    pool_mn[0] = '0;
    pool_hr[1] = HourMax;
    pool_mn[1] = MinuteMax;
    pool_hr[2] = 5'($urandom_range(23));
    pool_mn[2] = 6'($urandom_range(59));
    pool_hr[3] = 5'($urandom_range(23));
    pool_mn[3] = 6'($urandom_range(59));
    cur_year  = 12'd2024;
    cur_month = 4'd6;
    cur_day   = 5'd15;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: a check fires nothing, every edit misses.
    send_word(minute_tick(NoWeekday, 5'd0, 6'd0, 12'd2024, 4'd1, 5'd1));
    send_word(alarm_edit(KIND_UPDATE, 16'd1, 5'd1, 6'd1, 7'h7F, 1'b1, 8'h01, 4'h1));
    send_word(alarm_edit(KIND_DELETE, 16'd1, 5'd1, 6'd1, 7'h7F, 1'b1, 8'h01, 4'h1));
    send_word(alarm_edit(KIND_ENABLE, 16'd1, 5'd1, 6'd1, 7'h7F, 1'b1, 8'h01, 4'h1));
    // Bad adds spend ids one, two and three; hour is tested before minute.
    send_word(alarm_add(5'd24, 6'd0, 7'h7F, 1'b1, 8'h01, 4'h1));
    send_word(alarm_add(5'd31, 6'd63, 7'h7F, 1'b1, 8'h01, 4'h1));
    send_word(alarm_add(5'd0, 6'd60, 7'h7F, 1'b1, 8'h01, 4'h1));
    // Good adds at the extremes of the time and data fields, one disabled.
    send_word(alarm_add(5'd0, 6'd0, 7'h7F, 1'b1, 8'hFF, 4'hF));
    send_word(alarm_add(HourMax, MinuteMax, 7'h01, 1'b1, 8'h00, 4'h0));
    send_word(alarm_add(5'd0, 6'd0, 7'h7F, 1'b0, 8'h5A, 4'h6));
    // Fires once per date, never on weekday seven.
    send_word(minute_tick(3'd0, 5'd0, 6'd0, 12'd2024, 4'd1, 5'd1));
    send_word(minute_tick(3'd0, 5'd0, 6'd0, 12'd2024, 4'd1, 5'd1));
    send_word(minute_tick(NoWeekday, 5'd0, 6'd0, 12'd2024, 4'd1, 5'd2));
    send_word(alarm_edit(KIND_ENABLE, 16'd6, 5'd0, 6'd0, 7'h00, 1'b1, 8'h00, 4'h0));
    send_word(minute_tick(3'd2, 5'd0, 6'd0, 12'd2024, 4'd1, 5'd3));
    // Date code zero equals a fresh last run; the largest date wraps.
    send_word(minute_tick(3'd0, HourMax, MinuteMax, 12'd0, 4'd0, 5'd0));
    send_word(minute_tick(3'd0, HourMax, MinuteMax, 12'hFFF, 4'hF, 5'h1F));
    // Update takes any time and keeps the last run.
    send_word(alarm_edit(KIND_UPDATE, 16'd4, 5'd31, 6'd63, 7'h7F, 1'b1, 8'hA5, 4'h9));
    send_word(minute_tick(3'd3, 5'd31, 6'd63, 12'd2024, 4'd1, 5'd3));
    send_word(minute_tick(3'd3, 5'd31, 6'd63, 12'd2024, 4'd1, 5'd4));
    send_word(alarm_edit(KIND_DELETE, 16'd4, 5'd0, 6'd0, 7'h00, 1'b0, 8'h00, 4'h0));
    send_word(alarm_edit(KIND_DELETE, 16'd4, 5'd0, 6'd0, 7'h00, 1'b0, 8'h00, 4'h0));
    // Kinds with no operation.
    for (int s = 0; s < 3; s++) begin
      w = noise_word();
      w.kind = FirstSpareKind + 3'(s);
      send_word(w);
    end
    drain_results();

    run_random(150);

    // Full table: the remaining slots are filled at one time so that a single check
    // fires many words; an add on the full table takes no id.
    skip_ids(2);
    while (live_ids.size() < MaxEntriesDef) begin
      send_word(alarm_add(pool_hr[0], pool_mn[0], 7'h7F, 1'b1, 8'($urandom),
                          4'($urandom)));
    end
    send_word(alarm_add(pool_hr[1], pool_mn[1], 7'h7F, 1'b1, 8'h11, 4'h1));
    send_word(minute_tick(3'd4, pool_hr[0], pool_mn[0], 12'd2050, 4'd7, 5'd4));
    send_word(minute_tick(3'd4, pool_hr[0], pool_mn[0], 12'd2050, 4'd7, 5'd4));
    send_word(alarm_edit(KIND_ENABLE, live_ids[0], 5'd0, 6'd0, 7'h00, 1'b0, 8'h00, 4'h0));
    send_word(minute_tick(3'd5, pool_hr[0], pool_mn[0], 12'd2050, 4'd7, 5'd5));
    send_word(alarm_edit(KIND_UPDATE, live_ids[15], pool_hr[1], pool_mn[1], 7'h7F, 1'b1,
                         8'h77, 4'h7));
    send_word(alarm_edit(KIND_DELETE, live_ids[0], 5'd0, 6'd0, 7'h00, 1'b0, 8'h00, 4'h0));
    send_word(minute_tick(3'd6, pool_hr[0], pool_mn[0], 12'd2050, 4'd7, 5'd6));
    send_word(minute_tick(3'd6, pool_hr[1], pool_mn[1], 12'd2050, 4'd7, 5'd6));
    drain_results();

    run_random(150);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("Checked %0d result words, %0d of them fired alarms.", words_checked, fires_seen);
    $display("Covered directed edge cases, random edits and checks with stalls, and a full table.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin : watchdog
    #4_000_000;
    $display("Timeout with %0d result words still due.", pending_count);
    $display("Test completed with failures");
    $finish;
  end

endmodule
